[rtl/ect_pkg.sv]
`default_nettype none
package ect_pkg;

  localparam int IMAGE_SIDE  = 80;
  localparam int TRACE_STEPS = 100;
  localparam int NPIX        = IMAGE_SIDE * IMAGE_SIDE;
  localparam int AW          = $clog2(NPIX);
  localparam int CW          = 7;
  localparam int STEP_W      = $clog2(TRACE_STEPS);
  localparam int INNER_LO    = 2;
  localparam int INNER_HI    = IMAGE_SIDE - 3;
  localparam int CENTER_COL  = IMAGE_SIDE / 2;
  localparam int AHEAD_ROW   = IMAGE_SIDE - 10;
  localparam int DEFAULT_POS = 40;
  localparam int XW          = 26;
  localparam int ZW          = 20;
  localparam int Z_MAX       = 900 * 256;

  localparam logic [1:0] EDGE_NONE = 2'd0;
  localparam logic [1:0] EDGE_OPEN = 2'd1;
  localparam logic [1:0] EDGE_MARK = 2'd2;

  localparam logic [1:0] REG_FOLLOW_SIDE = 2'd0;
  localparam logic [1:0] REG_SCAN_START  = 2'd1;
  localparam logic [1:0] REG_MIN_GAP     = 2'd2;

  localparam logic [2:0] DIR_START = 3'd6;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [1:0]    data;
  } wr_req_t;

  typedef struct packed {
    logic          follow_side;
    logic [CW-1:0] scan_start_row;
    logic [CW-1:0] min_gap;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_INIT, ST_SCAN_RD, ST_SCAN_WT, ST_SCAN_EVAL,
    ST_MARK_L, ST_MARK_R, ST_TRACE_RD, ST_TRACE_WT, ST_CORDIC_INIT,
    ST_CORDIC, ST_FINISH
  } back_state_t;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] row,
                                            input logic [CW-1:0] col);
    logic [AW-1:0] prod;
    prod = AW'(row) * AW'(IMAGE_SIDE);
    return prod + AW'(col);
  endfunction

  function automatic logic [CW-1:0] step_dr(input logic [2:0] d);
    logic [CW-1:0] v;
    case (d)
      3'd0, 3'd1, 3'd7: v = {CW{1'b1}};
      3'd3, 3'd4, 3'd5: v = CW'(1);
      default:          v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [CW-1:0] step_dc(input logic [2:0] d);
    logic [CW-1:0] v;
    case (d)
      3'd1, 3'd2, 3'd3: v = CW'(1);
      3'd5, 3'd6, 3'd7: v = {CW{1'b1}};
      default:          v = '0;
    endcase
    return v;
  endfunction

  // atan(2^-i), tenths of a degree, Q8
  function automatic logic signed [ZW-1:0] atan_q8(input logic [3:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      4'd0:  v = ZW'(115200);
      4'd1:  v = ZW'(68007);
      4'd2:  v = ZW'(35933);
      4'd3:  v = ZW'(18240);
      4'd4:  v = ZW'(9155);
      4'd5:  v = ZW'(4582);
      4'd6:  v = ZW'(2292);
      4'd7:  v = ZW'(1146);
      4'd8:  v = ZW'(573);
      4'd9:  v = ZW'(286);
      4'd10: v = ZW'(143);
      4'd11: v = ZW'(72);
      4'd12: v = ZW'(36);
      4'd13: v = ZW'(18);
      4'd14: v = ZW'(9);
      default: v = ZW'(4);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/ect_front.sv]
`default_nettype none
module ect_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic            pixel,
  output ect_pkg::wr_req_t     wr_req,
  output logic                 frame_done
);
  import ect_pkg::*;

  logic [CW-1:0]         cur_row;
  logic [CW-1:0]         cur_col;
  logic [IMAGE_SIDE-1:0] line_sr;  // [k] = pixel received k+1 requests ago
  logic [CW-1:0]         e_row;
  logic                  inner;
  logic                  is_edge;

  // edge of the pixel one row above: it differs from its right or lower neighbor
  assign e_row   = cur_row - CW'(1);
  assign inner   = (e_row >= CW'(INNER_LO)) && (e_row <= CW'(INNER_HI)) &&
                   (cur_col >= CW'(INNER_LO)) && (cur_col <= CW'(INNER_HI));
  assign is_edge = (line_sr[IMAGE_SIDE-1] != line_sr[IMAGE_SIDE-2]) ||
                   (line_sr[IMAGE_SIDE-1] != pixel);

  always_comb begin
    wr_req.en   = accept && (cur_row != '0);
    wr_req.addr = addr_of(e_row, cur_col);
    wr_req.data = (inner && is_edge) ? EDGE_OPEN : EDGE_NONE;
  end

  assign frame_done = accept && (cur_row == CW'(IMAGE_SIDE - 1)) &&
                      (cur_col == CW'(IMAGE_SIDE - 1));

  always_ff @(posedge clk) begin
    if (accept) begin
      line_sr <= {line_sr[IMAGE_SIDE-2:0], pixel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
    end else if (accept) begin
      if (cur_col == CW'(IMAGE_SIDE - 1)) begin
        cur_col <= '0;
        cur_row <= (cur_row == CW'(IMAGE_SIDE - 1)) ? '0 : cur_row + CW'(1);
      end else begin
        cur_col <= cur_col + CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/ect_queue.sv]
`default_nettype none
module ect_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire logic pop,
  output logic      pending
);
  logic [1:0] count;

  assign pending = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop && pending})
        2'b10:   count <= (count == 2'd2) ? count : count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/ect_back.sv]
`default_nettype none
module ect_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ect_pkg::wr_req_t           front_wr,
  input  wire ect_pkg::cfg_t              cfg,
  input  wire logic                       pending,
  output logic                            pop,
  output logic                            active,
  output logic                            result_valid,
  output logic [ect_pkg::CW-1:0]          end_row,
  output logic [ect_pkg::CW-1:0]          end_col,
  output logic [ect_pkg::CW-1:0]          moves_made,
  output logic                            start_found,
  output logic signed [10:0]              angle_tenths
);
  import ect_pkg::*;

  logic [1:0] edge_mem [NPIX];
  logic [1:0] rd_data;

  back_state_t state, state_next;

  logic [CW-1:0]     srow, scol, lcol, rcol, lrow;
  logic              row_hit, found;
  logic [CW-1:0]     tr, tc, nb_row, nb_col, moves;
  logic [2:0]        pdir, cur, kcnt;
  logic [STEP_W-1:0] nstep;
  logic signed [XW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic [3:0]        iter;
  logic              neg;

  logic          b_we;
  logic [AW-1:0] b_waddr, raddr;
  logic [2:0]    cur_c;
  logic [CW-1:0] nb_row_c, nb_col_c;
  logic signed [CW:0] dy, dx;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] zc;
  logic [9:0]    mag;

  assign cur_c    = pdir + kcnt;
  assign nb_row_c = tr + step_dr(cur_c);
  assign nb_col_c = tc + step_dc(cur_c);
  assign dy       = $signed({1'b0, tc}) - (CW+1)'(CENTER_COL);
  assign dx       = (CW+1)'(AHEAD_ROW) - $signed({1'b0, tr});
  assign xs       = cx >>> iter;
  assign ys       = cy >>> iter;
  assign zc       = (cz < 0) ? '0 : ((cz > ZW'(Z_MAX)) ? ZW'(Z_MAX) : cz);
  assign mag      = 10'((zc + ZW'(128)) >>> 8);

  always_comb begin
    b_we    = 1'b0;
    b_waddr = addr_of(nb_row, nb_col);
    unique case (state)
      ST_MARK_L: begin
        b_we    = 1'b1;
        b_waddr = addr_of(lrow, lcol);
      end
      ST_MARK_R: begin
        b_we    = 1'b1;
        b_waddr = addr_of(lrow, rcol);
      end
      ST_TRACE_WT: b_we = (rd_data == EDGE_OPEN);
      default: b_we = 1'b0;
    endcase
    raddr = (state == ST_TRACE_RD) ? addr_of(nb_row_c, nb_col_c) : addr_of(srow, scol);
  end

  always_ff @(posedge clk) begin
    if (front_wr.en) begin
      edge_mem[front_wr.addr] <= front_wr.data;
    end else if (b_we) begin
      edge_mem[b_waddr] <= EDGE_MARK;
    end
    rd_data <= edge_mem[raddr];
  end

  assign active = (state != ST_IDLE);
  assign pop    = (state == ST_IDLE) && pending;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (pending) state_next = ST_SCAN_INIT;
      ST_SCAN_INIT: state_next = (cfg.scan_start_row < CW'(INNER_LO)) ? ST_MARK_L : ST_SCAN_RD;
      ST_SCAN_RD:   state_next = ST_SCAN_WT;
      ST_SCAN_WT:   state_next = (scol == CW'(INNER_HI)) ? ST_SCAN_EVAL : ST_SCAN_RD;
      ST_SCAN_EVAL: begin
        if ((row_hit && ((rcol - lcol) > cfg.min_gap)) || srow == CW'(INNER_LO)) begin
          state_next = ST_MARK_L;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_MARK_L:    state_next = ST_MARK_R;
      ST_MARK_R:    state_next = ST_TRACE_RD;
      ST_TRACE_RD:  state_next = ST_TRACE_WT;
      ST_TRACE_WT: begin
        if (rd_data == EDGE_OPEN || kcnt == 3'd7) begin
          state_next = (nstep == STEP_W'(TRACE_STEPS - 1)) ? ST_CORDIC_INIT : ST_TRACE_RD;
        end else begin
          state_next = ST_TRACE_RD;
        end
      end
      ST_CORDIC_INIT: state_next = (dx == '0) ? ST_FINISH : ST_CORDIC;
      ST_CORDIC:    if (iter == 4'd15) state_next = ST_FINISH;
      ST_FINISH:    state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_SCAN_INIT: begin
        srow    <= (cfg.scan_start_row > CW'(INNER_HI)) ? CW'(INNER_HI) : cfg.scan_start_row;
        scol    <= CW'(INNER_LO);
        lcol    <= CW'(DEFAULT_POS);
        rcol    <= CW'(DEFAULT_POS);
        lrow    <= CW'(DEFAULT_POS);
        row_hit <= 1'b0;
        found   <= 1'b0;
      end
      ST_SCAN_WT: begin
        if (rd_data == EDGE_OPEN) begin
          if (!row_hit) lcol <= scol;
          rcol    <= scol;
          row_hit <= 1'b1;
        end
        scol <= scol + CW'(1);
      end
      ST_SCAN_EVAL: begin
        if (row_hit && ((rcol - lcol) > cfg.min_gap)) begin
          lrow  <= srow;
          found <= 1'b1;
        end
        srow    <= srow - CW'(1);
        scol    <= CW'(INNER_LO);
        row_hit <= 1'b0;
      end
      ST_MARK_R: begin
        tr    <= lrow;
        tc    <= cfg.follow_side ? rcol : lcol;
        pdir  <= DIR_START;
        kcnt  <= '0;
        nstep <= '0;
        moves <= '0;
      end
      ST_TRACE_RD: begin
        cur    <= cur_c;
        nb_row <= nb_row_c;
        nb_col <= nb_col_c;
      end
      ST_TRACE_WT: begin
        if (rd_data == EDGE_OPEN || kcnt == 3'd7) begin
          if (rd_data == EDGE_OPEN) begin
            tr    <= nb_row;
            tc    <= nb_col;
            moves <= moves + CW'(1);
          end
          pdir  <= cur - 3'd2;
          kcnt  <= '0;
          nstep <= nstep + STEP_W'(1);
        end else begin
          kcnt <= kcnt + 3'd1;
        end
      end
      ST_CORDIC_INIT: begin
        cx   <= XW'(dx < 0 ? -dx : dx) <<< 16;
        cy   <= XW'(dy < 0 ? -dy : dy) <<< 16;
        cz   <= '0;
        iter <= '0;
        neg  <= (dy < 0) != (dx < 0);
      end
      ST_CORDIC: begin
        if (cy > 0) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_q8(iter);
        end else if (cy < 0) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_q8(iter);
        end
        iter <= iter + 4'd1;
      end
      ST_FINISH: begin
        end_row     <= tr;
        end_col     <= tc;
        moves_made  <= moves;
        start_found <= found;
        if (dx == '0) begin
          angle_tenths <= (dy > 0) ? 11'sd900 : ((dy < 0) ? -11'sd900 : 11'sd0);
        end else begin
          angle_tenths <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/edge_chain_code_line_tracker_unit.sv]
`default_nettype none
// Edge chain tracker. Pixels of an 80x80 binary frame come in raster order,
// one per request, and the edge map is built on the fly from an 80-pixel line
// buffer, so one pixel is loaded per cycle while busy is low. After the last
// pixel busy rises while the back end scans the edge map row by row for the
// start row, traces 100 chain steps (probing the neighbors of the current
// pixel in turn at each step) and runs a CORDIC arctangent. One result per
// frame is shown for one cycle on result_valid; the receiver cannot stall it.
// Configuration writes are always taken.
module edge_chain_code_line_tracker_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                pixel,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [6:0]          cfg_data,
  output logic                     result_valid,
  output logic [6:0]               end_row,
  output logic [6:0]               end_col,
  output logic [6:0]               moves_made,
  output logic                     start_found,
  output logic signed [10:0]       angle_tenths
);
  import ect_pkg::*;

  wr_req_t front_wr;
  cfg_t    cfg;
  logic    accept, frame_done, pending, pop, active;

  assign accept    = start && !busy;
  assign busy      = pending || active;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.follow_side    <= 1'b0;
      cfg.scan_start_row <= CW'(60);
      cfg.min_gap        <= CW'(4);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FOLLOW_SIDE: cfg.follow_side    <= cfg_data[0];
        REG_SCAN_START:  cfg.scan_start_row <= cfg_data;
        REG_MIN_GAP:     cfg.min_gap        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ect_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .pixel      (pixel),
    .wr_req     (front_wr),
    .frame_done (frame_done)
  );

  ect_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (frame_done),
    .pop     (pop),
    .pending (pending)
  );

  ect_back u_back (
    .clk          (clk),
    .rst          (rst),
    .front_wr     (front_wr),
    .cfg          (cfg),
    .pending      (pending),
    .pop          (pop),
    .active       (active),
    .result_valid (result_valid),
    .end_row      (end_row),
    .end_col      (end_col),
    .moves_made   (moves_made),
    .start_found  (start_found),
    .angle_tenths (angle_tenths)
  );

endmodule
`default_nettype wire
